[sv/framed_packet_receiver_core_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the framed packet receiver
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef FRAMED_PACKET_RECEIVER_CORE_DEFINES_SVH
`define FRAMED_PACKET_RECEIVER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// check a property on every rising edge, ignored while reset is high
`define FPR_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// check a property on every rising edge, including during reset
`define FPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FPR_ASSERT_CLK(lbl, clk, rst, prop, msg)
`define FPR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[sv/fpr_pkg.sv]
// ---------------------------------------------------------------------------
// Framed packet receiver package
// Frame constants, phase codes, event codes and the per-byte result type.
// ---------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

   // framing and type bytes
   localparam logic [7:0] START_BYTE      = 8'h7E;
   localparam logic [7:0] TYPE_NEED_REPLY = 8'hA0;
   localparam logic [7:0] TYPE_PLAIN      = 8'h20;
   localparam logic [7:0] TYPE_REPLY      = 8'h08;

   // parser phases
   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_ID   = 3'd1;
   localparam logic [2:0] PH_SUM  = 3'd2;
   localparam logic [2:0] PH_PORT = 3'd3;
   localparam logic [2:0] PH_TYPE = 3'd4;
   localparam logic [2:0] PH_LEN  = 3'd5;
   localparam logic [2:0] PH_BODY = 3'd6;

   // event kinds
   localparam logic [1:0] EV_PAYLOAD  = 2'd0;
   localparam logic [1:0] EV_GOOD_SUM = 2'd1;
   localparam logic [1:0] EV_BAD_SUM  = 2'd2;

   // type classes
   localparam logic [1:0] TC_NEED_REPLY = 2'd0;
   localparam logic [1:0] TC_PLAIN      = 2'd1;
   localparam logic [1:0] TC_REPLY      = 2'd2;
   localparam logic [1:0] TC_OTHER      = 2'd3;

   // result of one byte, as handed from the parser to the output register
   typedef struct packed {
      logic       has_result;
      logic [1:0] event_kind;
      logic [7:0] payload_byte;
      logic [7:0] packet_id;
      logic [7:0] port_number;
      logic [1:0] type_class;
      logic       is_duplicate;
      logic [7:0] payload_length;
   } fpr_result_type;

   function automatic logic [1:0] classify_type(input logic [7:0] t);
      logic [1:0] tc;
      if (t == TYPE_NEED_REPLY) begin
         tc = TC_NEED_REPLY;
      end else if (t == TYPE_PLAIN) begin
         tc = TC_PLAIN;
      end else if (t == TYPE_REPLY) begin
         tc = TC_REPLY;
      end else begin
         tc = TC_OTHER;
      end
      return tc;
   endfunction

endpackage

`default_nettype wire

[sv/fpr_parser.sv]
// ---------------------------------------------------------------------------
// Framed packet receiver byte parser
// Holds the frame state and works out the result of the byte on offer.
// ---------------------------------------------------------------------------
`default_nettype none

`include "framed_packet_receiver_core_defines.svh"

module fpr_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   take,
   input  wire logic [7:0]             rx_byte,
   output fpr_pkg::fpr_result_type     rslt
);
   import fpr_pkg::*;

   logic [2:0] phase_ff, phase_in;
   logic [7:0] hdr_id_ff, hdr_id_in;
   logic [7:0] expected_sum_ff, expected_sum_in;
   logic [7:0] hdr_port_ff, hdr_port_in;
   logic [7:0] hdr_type_ff, hdr_type_in;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] bytes_taken_ff, bytes_taken_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] last_good_id_ff, last_good_id_in;
   logic       sum_good;

   assign sum_good = (running_sum_ff == expected_sum_ff);

   // next frame state and the result of this byte
   always_comb begin
      phase_in        = phase_ff;
      hdr_id_in       = hdr_id_ff;
      expected_sum_in = expected_sum_ff;
      hdr_port_in     = hdr_port_ff;
      hdr_type_in     = hdr_type_ff;
      frame_length_in = frame_length_ff;
      bytes_taken_in  = bytes_taken_ff;
      running_sum_in  = running_sum_ff;
      last_good_id_in = last_good_id_ff;

      rslt                = '0;
      rslt.packet_id      = hdr_id_ff;
      rslt.port_number    = hdr_port_ff;
      rslt.type_class     = classify_type(hdr_type_ff);
      rslt.payload_length = frame_length_ff;

      case (phase_ff)
         PH_ID: begin
            hdr_id_in = rx_byte;
            phase_in  = PH_SUM;
         end
         PH_SUM: begin
            expected_sum_in = rx_byte;
            phase_in        = PH_PORT;
         end
         PH_PORT: begin
            hdr_port_in = rx_byte;
            phase_in    = PH_TYPE;
         end
         PH_TYPE: begin
            hdr_type_in = rx_byte;
            phase_in    = PH_LEN;
         end
         PH_LEN: begin
            frame_length_in = rx_byte;
            phase_in        = PH_BODY;
         end
         PH_BODY: begin
            rslt.has_result = 1'b1;
            if (bytes_taken_ff < frame_length_ff) begin
               // pass the payload byte out and add it into the sum
               running_sum_in    = running_sum_ff + rx_byte;
               bytes_taken_in    = bytes_taken_ff + 8'd1;
               rslt.event_kind   = EV_PAYLOAD;
               rslt.payload_byte = rx_byte;
            end else begin
               // trailer: give the verdict and drop back to hunting
               rslt.event_kind   = sum_good ? EV_GOOD_SUM : EV_BAD_SUM;
               rslt.is_duplicate = (hdr_type_ff == TYPE_NEED_REPLY) &&
                                   (hdr_id_ff == last_good_id_ff);
               if (sum_good) begin
                  last_good_id_in = hdr_id_ff;
               end
               phase_in        = PH_HUNT;
               expected_sum_in = '0;
               hdr_port_in     = '0;
               hdr_type_in     = '0;
               frame_length_in = '0;
               bytes_taken_in  = '0;
               running_sum_in  = '0;
            end
         end
         default: begin
            phase_in = (rx_byte == START_BYTE) ? PH_ID : PH_HUNT;
         end
      endcase
   end

   // advance the frame state on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         hdr_id_ff       <= '0;
         expected_sum_ff <= '0;
         hdr_port_ff     <= '0;
         hdr_type_ff     <= '0;
         frame_length_ff <= '0;
         bytes_taken_ff  <= '0;
         running_sum_ff  <= '0;
         last_good_id_ff <= '0;
      end else if (take) begin
         phase_ff        <= phase_in;
         hdr_id_ff       <= hdr_id_in;
         expected_sum_ff <= expected_sum_in;
         hdr_port_ff     <= hdr_port_in;
         hdr_type_ff     <= hdr_type_in;
         frame_length_ff <= frame_length_in;
         bytes_taken_ff  <= bytes_taken_in;
         running_sum_ff  <= running_sum_in;
         last_good_id_ff <= last_good_id_in;
      end
   end

   // checks
   `FPR_ASSERT_CLK(a_count_in_range, clock, reset, (phase_ff != PH_BODY) || (bytes_taken_ff <= frame_length_ff), "payload count ran past the frame length")
   `FPR_ASSERT_CLK(a_verdict_ends_frame, clock, reset, take && rslt.has_result && (rslt.event_kind != EV_PAYLOAD) |=> (phase_ff == PH_HUNT) && (running_sum_ff == 8'd0), "frame state not cleared after verdict")
   `FPR_ASSERT_CLK(a_good_updates_id, clock, reset, take && rslt.has_result && (rslt.event_kind == EV_GOOD_SUM) |=> (last_good_id_ff == $past(hdr_id_ff)), "last good id not updated")
   `FPR_ASSERT_CLK(a_dup_on_verdict, clock, reset, rslt.is_duplicate |-> rslt.has_result && (rslt.event_kind != EV_PAYLOAD) && (rslt.type_class == TC_NEED_REPLY), "duplicate flag outside a need-reply verdict")

endmodule

`default_nettype wire

[sv/framed_packet_receiver_core.sv]
// A result is registered and appears on rsp_ in the cycle after its byte is taken.
// Throughput: one byte per cycle while req_stall is low; the parser state steps once per transfer.
// Input stalls only while a result is held and the output side stalls.
// Reset (synchronous, active high) returns the parser to hunting for the
// start byte, clears all header state and the last good id, and empties rsp_.
// ---------------------------------------------------------------------------
// Framed packet receiver core
// Start-byte framed packet parser with an 8-bit payload checksum.
// ---------------------------------------------------------------------------
`default_nettype none

module framed_packet_receiver_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_event_kind,
   output logic [7:0]      rsp_payload_byte,
   output logic [7:0]      rsp_packet_id,
   output logic [7:0]      rsp_port_number,
   output logic [1:0]      rsp_type_class,
   output logic            rsp_is_duplicate,
   output logic [7:0]      rsp_payload_length
);
   import fpr_pkg::*;

   fpr_result_type rslt;
   fpr_result_type rsp_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           take;

   // hold input while the result register is full and not being drained
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign take      = req_valid && !req_stall;

   fpr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (req_rx_byte),
      .rslt    (rslt)
   );

   // result register occupancy
   always_comb begin
      if (take && rslt.has_result) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the result payload on a transfer that yields one
   always_ff @(posedge clock) begin
      if (take && rslt.has_result) begin
         rsp_ff <= rslt;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_kind     = rsp_ff.event_kind;
   assign rsp_payload_byte   = rsp_ff.payload_byte;
   assign rsp_packet_id      = rsp_ff.packet_id;
   assign rsp_port_number    = rsp_ff.port_number;
   assign rsp_type_class     = rsp_ff.type_class;
   assign rsp_is_duplicate   = rsp_ff.is_duplicate;
   assign rsp_payload_length = rsp_ff.payload_length;

endmodule

`default_nettype wire
